/* hw/rtl/clkf_pkg.sv */
// Shared types, frame layout codes and helper functions for the LCD clock.
package clkf_pkg;

  typedef struct packed {
    logic [3:0] hour_tens;
    logic [3:0] hour_ones;
    logic [3:0] min_tens;
    logic [3:0] min_ones;
    logic [3:0] sec_tens;
    logic [3:0] sec_ones;
  } time_bcd_t;

  typedef struct packed {
    logic      valid;
    time_bcd_t t;
  } frame_req_t;

  localparam logic [7:0] SYNC_INSTR = 8'hF8;
  localparam logic [7:0] SYNC_DATA  = 8'hFA;
  localparam logic [7:0] CMD_CLEAR  = 8'h01;
  localparam logic [7:0] CMD_POS_H  = 8'h80;
  localparam logic [7:0] CMD_POS_M  = 8'h82;
  localparam logic [7:0] CMD_POS_S  = 8'h84;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;
  localparam logic [7:0] TICK_DIVIDE_RESET = 8'd8;

  localparam logic [3:0] U_CLEAR   = 4'd0;
  localparam logic [3:0] U_POS_H   = 4'd1;
  localparam logic [3:0] U_H_TENS  = 4'd2;
  localparam logic [3:0] U_H_ONES  = 4'd3;
  localparam logic [3:0] U_COLON_1 = 4'd4;
  localparam logic [3:0] U_NUL_1   = 4'd5;
  localparam logic [3:0] U_POS_M   = 4'd6;
  localparam logic [3:0] U_M_TENS  = 4'd7;
  localparam logic [3:0] U_M_ONES  = 4'd8;
  localparam logic [3:0] U_COLON_2 = 4'd9;
  localparam logic [3:0] U_NUL_2   = 4'd10;
  localparam logic [3:0] U_POS_S   = 4'd11;
  localparam logic [3:0] U_S_TENS  = 4'd12;
  localparam logic [3:0] U_S_ONES  = 4'd13;

  localparam logic [1:0] B_SYNC = 2'd0;
  localparam logic [1:0] B_HIGH = 2'd1;
  localparam logic [1:0] B_LOW  = 2'd2;

  function automatic logic [7:0] bcd_inc(input logic [3:0] tens, input logic [3:0] ones);
    logic [7:0] r;
    if (ones == 4'd9) r = {tens + 4'd1, 4'd0};
    else              r = {tens, ones + 4'd1};
    return r;
  endfunction

  function automatic logic bcd_ge(input logic [3:0] tens, input logic [3:0] ones,
                                  input logic [3:0] lim_tens, input logic [3:0] lim_ones);
    return (tens > lim_tens) || ((tens == lim_tens) && (ones >= lim_ones));
  endfunction

  function automatic logic [7:0] ascii_digit(input logic [3:0] d);
    return {ASCII_DIGIT_HI, d};
  endfunction

  function automatic logic [8:0] unit_value(input logic [3:0] unit, input time_bcd_t t);
    logic [8:0] r;
    unique case (unit)
      U_CLEAR:   r = {1'b0, CMD_CLEAR};
      U_POS_H:   r = {1'b0, CMD_POS_H};
      U_H_TENS:  r = {1'b1, ascii_digit(t.hour_tens)};
      U_H_ONES:  r = {1'b1, ascii_digit(t.hour_ones)};
      U_COLON_1: r = {1'b1, CHAR_COLON};
      U_NUL_1:   r = {1'b1, CHAR_NUL};
      U_POS_M:   r = {1'b0, CMD_POS_M};
      U_M_TENS:  r = {1'b1, ascii_digit(t.min_tens)};
      U_M_ONES:  r = {1'b1, ascii_digit(t.min_ones)};
      U_COLON_2: r = {1'b1, CHAR_COLON};
      U_NUL_2:   r = {1'b1, CHAR_NUL};
      U_POS_S:   r = {1'b0, CMD_POS_S};
      U_S_TENS:  r = {1'b1, ascii_digit(t.sec_tens)};
      U_S_ONES:  r = {1'b1, ascii_digit(t.sec_ones)};
      default:   r = {1'b0, CHAR_NUL};
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/clkf_front.sv */
// Front end: accepts requests, collects set digits, keeps time and queues frame jobs.
module clkf_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,
  input  logic               s_tuser,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               q_full,
  output clkf_pkg::frame_req_t q_wr
);
  import clkf_pkg::*;

  time_bcd_t  tm;
  time_bcd_t  tm_adv;
  time_bcd_t  tm_load;
  logic [7:0] tick_count;
  logic [7:0] tick_divide;
  logic       time_set;
  logic [2:0] digit_index;
  logic [3:0] digit_store [6];
  logic [3:0] rx_digit;
  logic       accept;
  logic       is_load;
  logic       is_tick;
  logic       is_advance;
  logic       sec_wrap;
  logic       min_wrap;
  logic       hour_wrap;
  logic       min_carry;
  logic       hour_carry;
  logic [7:0] sec_inc;
  logic [7:0] min_inc;
  logic [7:0] hour_inc;

  assign s_tready   = !q_full;
  assign accept     = s_tvalid && s_tready;
  assign is_load    = accept && s_tuser && (digit_index == 3'd5);
  assign is_tick    = accept && !s_tuser && time_set;
  assign is_advance = is_tick && (tick_count == tick_divide);

  assign rx_digit = ((s_tdata[7:4] == ASCII_DIGIT_HI) && (s_tdata[3:0] <= 4'd9)) ?
                    s_tdata[3:0] : 4'd0;

  assign tm_load = '{hour_tens: digit_store[0], hour_ones: digit_store[1],
                     min_tens:  digit_store[2], min_ones:  digit_store[3],
                     sec_tens:  digit_store[4], sec_ones:  rx_digit};

  always_comb begin
    sec_inc    = bcd_inc(tm.sec_tens, tm.sec_ones);
    min_inc    = bcd_inc(tm.min_tens, tm.min_ones);
    hour_inc   = bcd_inc(tm.hour_tens, tm.hour_ones);
    tm_adv     = tm;
    sec_wrap   = bcd_ge(tm.sec_tens, tm.sec_ones, 4'd5, 4'd9);
    min_carry  = sec_wrap;
    if (sec_wrap) begin
      tm_adv.sec_tens = 4'd0;
      tm_adv.sec_ones = 4'd0;
    end else begin
      {tm_adv.sec_tens, tm_adv.sec_ones} = sec_inc;
    end
    min_wrap = bcd_ge(tm.min_tens, tm.min_ones, 4'd6, 4'd0) ||
               (min_carry && (tm.min_tens == 4'd5) && (tm.min_ones == 4'd9));
    hour_carry = min_wrap;
    if (min_wrap) begin
      tm_adv.min_tens = 4'd0;
      tm_adv.min_ones = 4'd0;
    end else if (min_carry) begin
      {tm_adv.min_tens, tm_adv.min_ones} = min_inc;
    end
    hour_wrap = bcd_ge(tm.hour_tens, tm.hour_ones, 4'd2, 4'd4) ||
                (hour_carry && (tm.hour_tens == 4'd2) && (tm.hour_ones == 4'd3));
    if (hour_wrap) begin
      tm_adv = '0;
    end else if (hour_carry) begin
      {tm_adv.hour_tens, tm_adv.hour_ones} = hour_inc;
    end
  end

  assign q_wr.valid = is_load || is_advance;
  assign q_wr.t     = is_load ? tm_load : tm_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      tm          <= '0;
      tick_count  <= '0;
      tick_divide <= TICK_DIVIDE_RESET;
      time_set    <= 1'b0;
      digit_index <= '0;
    end else begin
      if (cfg_wr_en) begin
        tick_divide <= cfg_wr_data;
      end
      if (accept && s_tuser) begin
        digit_index <= is_load ? 3'd0 : digit_index + 3'd1;
      end
      if (is_load) begin
        tm       <= tm_load;
        time_set <= 1'b1;
      end else if (is_advance) begin
        tm         <= tm_adv;
        tick_count <= '0;
      end else if (is_tick) begin
        tick_count <= tick_count + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tuser && (digit_index < 3'd6)) begin
      digit_store[digit_index] <= rx_digit;
    end
  end

endmodule

/* hw/rtl/clkf_queue.sv */
// Small FIFO of pending frame jobs between the front and back ends.
module clkf_queue #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  clkf_pkg::frame_req_t wr,
  output logic                 full,
  input  logic                 pop,
  output clkf_pkg::frame_req_t head
);
  import clkf_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  time_bcd_t     mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head.valid = (count != '0);
  assign head.t     = mem[rd_ptr];
  assign do_push    = wr.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr.t;
    end
  end

endmodule

/* hw/rtl/clkf_back.sv */
// Back end: walks a frame job byte by byte into the output register.
module clkf_back (
  input  logic                 clk,
  input  logic                 rst,
  input  clkf_pkg::frame_req_t head,
  output logic                 pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,
  output logic                 m_tlast
);
  import clkf_pkg::*;

  time_bcd_t  cur;
  logic       active;
  logic [3:0] unit;
  logic [1:0] sub;
  logic       load;
  logic       emit;
  time_bcd_t  sel_t;
  logic [3:0] sel_unit;
  logic [1:0] sel_sub;
  logic [8:0] uval;
  logic [7:0] byte_next;
  logic       last_next;
  logic [3:0] unit_next;
  logic [1:0] sub_next;

  assign load     = !m_tvalid || m_tready;
  assign emit     = load && (active || head.valid);
  assign pop      = load && !active && head.valid;
  assign sel_t    = active ? cur : head.t;
  assign sel_unit = active ? unit : U_CLEAR;
  assign sel_sub  = active ? sub : B_SYNC;
  assign uval     = unit_value(sel_unit, sel_t);
  assign last_next = (sel_unit == U_S_ONES) && (sel_sub == B_LOW);

  always_comb begin
    unique case (sel_sub)
      B_SYNC:  byte_next = uval[8] ? SYNC_DATA : SYNC_INSTR;
      B_HIGH:  byte_next = {uval[7:4], 4'h0};
      B_LOW:   byte_next = {uval[3:0], 4'h0};
      default: byte_next = 8'h00;
    endcase
    if (sel_sub == B_LOW) begin
      sub_next  = B_SYNC;
      unit_next = sel_unit + 4'd1;
    end else begin
      sub_next  = sel_sub + 2'd1;
      unit_next = sel_unit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      m_tvalid <= 1'b0;
      unit     <= U_CLEAR;
      sub      <= B_SYNC;
    end else if (load) begin
      m_tvalid <= emit;
      if (emit) begin
        active <= !last_next;
        unit   <= unit_next;
        sub    <= sub_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head.t;
    end
    if (emit) begin
      m_tdata <= byte_next;
      m_tlast <= last_next;
    end
  end

endmodule

/* hw/rtl/clock_with_serial_set_and_lcd_frames.sv */
// Top level of the time-of-day clock with serial time setting and LCD frame output.
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  tuser = mode, tdata = rx_byte
//  m_*       out        m_tvalid/m_tready  tdata = lcd_byte, tlast = last
//  cfg_*     in         cfg_wr_en          cfg_wr_data = tick_divide
//
// A load or an advance queues a frame job.
// Each frame is 42 output bytes, one per cycle unless the output stalls, made by the
// byte walker in the back end; frames follow each other without a gap while jobs wait.
// Input stalls only while the job queue is full; output stalls hold the register.
// Reset is synchronous.
module clock_with_serial_set_and_lcd_frames #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,     // [7:0] rx_byte
  input  logic       s_tuser,     // [0] mode
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,     // [7:0] lcd_byte
  output logic       m_tlast,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);
  import clkf_pkg::*;

  frame_req_t q_wr;
  frame_req_t q_head;
  logic       q_full;
  logic       q_pop;

  clkf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .q_wr        (q_wr)
  );

  clkf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (q_wr),
    .full (q_full),
    .pop  (q_pop),
    .head (q_head)
  );

  clkf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_wr.valid |-> !q_full)
    else $error("frame job queued while the queue is full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_head.valid)
    else $error("frame job taken from an empty queue");

  a_last_is_low_nibble: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[3:0] == 4'h0) && (m_tdata[7:4] <= 4'h9))
    else $error("frame end marked on a byte that is not a digit low nibble");

endmodule

/* test/clock_with_serial_set_and_lcd_frames_tb.sv */
// Self-checking testbench that predicts every LCD frame byte of the serial-set clock.
`timescale 1ns / 100ps

module clock_with_serial_set_and_lcd_frames_tb;
  import clkf_pkg::*;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_RX   = 1'b1;
  localparam int   FRAME_BEATS = 42;
  localparam int   SETTLE_CYCLES = 16;
  localparam int   MAX_REPORTS = 100;

  typedef struct packed {
    logic [7:0] lcd_byte;
    logic       last;
  } lcd_beat_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'd0;
  logic       s_tuser = MODE_TICK;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'd0;

  int send_idle_pct = 20;
  int recv_idle_pct = 55;
  int error_count = 0;

  lcd_beat_t lcd_expected[$];

  logic [6:0] clk_hours = 7'd0;
  logic [6:0] clk_minutes = 7'd0;
  logic [6:0] clk_seconds = 7'd0;
  logic [7:0] tick_cnt = 8'd0;
  logic [7:0] tick_div = TICK_DIVIDE_RESET;
  logic       time_loaded = 1'b0;
  logic [2:0] digit_pos = 3'd0;
  logic [3:0] digit_reg [6];
  int         frame_beat;

  clock_with_serial_set_and_lcd_frames dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),     // [7:0] rx_byte
    .s_tuser     (s_tuser),     // [0] mode
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),     // [7:0] lcd_byte
    .m_tlast     (m_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("clock_with_serial_set_and_lcd_frames: mismatch");
    $finish;
  end

  task automatic push_lcd_unit(input logic [7:0] v, input logic is_data);
    lcd_beat_t b;
    logic [7:0] beat_bytes [3];
    beat_bytes[0] = is_data ? SYNC_DATA : SYNC_INSTR;
    beat_bytes[1] = v & 8'hF0;
    beat_bytes[2] = {v[3:0], 4'h0};
    for (int i = 0; i < 3; i++) begin
      b.lcd_byte = beat_bytes[i];
      b.last = (frame_beat == FRAME_BEATS - 1);
      lcd_expected.push_back(b);
      frame_beat++;
    end
  endtask

  task automatic push_lcd_number(input logic [6:0] n);
    logic [6:0] r;
    logic [7:0] tens;
    logic [7:0] ones;
    r = n % 7'd100;
    tens = {1'b0, r / 7'd10};
    ones = {1'b0, r % 7'd10};
    push_lcd_unit(tens + 8'd48, 1'b1);
    push_lcd_unit(ones + 8'd48, 1'b1);
  endtask

  task automatic push_lcd_frame();
    frame_beat = 0;
    push_lcd_unit(CMD_CLEAR, 1'b0);
    push_lcd_unit(CMD_POS_H, 1'b0);
    push_lcd_number(clk_hours);
    push_lcd_unit(CHAR_COLON, 1'b1);
    push_lcd_unit(CHAR_NUL, 1'b1);
    push_lcd_unit(CMD_POS_M, 1'b0);
    push_lcd_number(clk_minutes);
    push_lcd_unit(CHAR_COLON, 1'b1);
    push_lcd_unit(CHAR_NUL, 1'b1);
    push_lcd_unit(CMD_POS_S, 1'b0);
    push_lcd_number(clk_seconds);
  endtask

  task automatic apply_clock_request(input logic mode, input logic [7:0] rx);
    logic [3:0] d;
    if (mode == MODE_RX) begin
      d = (rx >= 8'd48 && rx <= 8'd57) ? rx[3:0] : 4'd0;
      if (digit_pos < 3'd6) digit_reg[digit_pos] = d;
      digit_pos = digit_pos + 3'd1;
      if (digit_pos >= 3'd6) begin
        clk_hours = 7'(digit_reg[0] * 10 + digit_reg[1]);
        clk_minutes = 7'(digit_reg[2] * 10 + digit_reg[3]);
        clk_seconds = 7'(digit_reg[4] * 10 + digit_reg[5]);
        digit_pos = 3'd0;
        time_loaded = 1'b1;
        push_lcd_frame();
      end
    end else if (time_loaded) begin
      if (tick_cnt != tick_div) begin
        tick_cnt = tick_cnt + 8'd1;
      end else begin
        clk_seconds = clk_seconds + 7'd1;
        if (clk_seconds >= 7'd60) begin
          clk_seconds = 7'd0;
          clk_minutes = clk_minutes + 7'd1;
        end
        if (clk_minutes >= 7'd60) begin
          clk_minutes = 7'd0;
          clk_hours = clk_hours + 7'd1;
        end
        if (clk_hours >= 7'd24) begin
          clk_hours = 7'd0;
          clk_minutes = 7'd0;
          clk_seconds = 7'd0;
        end
        tick_cnt = 8'd0;
        push_lcd_frame();
      end
    end
  endtask

  task automatic send_request(input logic mode, input logic [7:0] rx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= rx;
    do @(posedge clk); while (!s_tready);
    apply_clock_request(mode, rx);
  endtask

  task automatic send_time(input string digits);
    for (int i = 0; i < 6; i++) send_request(MODE_RX, digits[i]);
  endtask

  task automatic send_ticks(input int n);
    for (int i = 0; i < n; i++) send_request(MODE_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_until_drained();
    s_tvalid <= 1'b0;
    while (lcd_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tick_divide(input logic [7:0] v);
    wait_until_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tick_div = v;
  endtask

  task automatic test_ticks_before_set();
    send_ticks(2);
  endtask

  task automatic test_non_digit_load();
    send_request(MODE_RX, 8'h2F);
    send_request(MODE_RX, 8'h3A);
    send_request(MODE_RX, 8'h00);
    send_request(MODE_RX, 8'hFF);
    send_request(MODE_RX, 8'h41);
    send_request(MODE_RX, 8'h39);
  endtask

  task automatic test_default_divide();
    send_ticks(9);
  endtask

  task automatic test_carry_and_rollover();
    write_tick_divide(8'd0);
    send_time("995999");
    send_ticks(1);
    send_time("235959");
    send_ticks(1);
  endtask

  task automatic test_divide_extremes();
    write_tick_divide(8'd1);
    send_ticks(4);
    write_tick_divide(8'd0);
    send_ticks(4);
    write_tick_divide(TICK_DIVIDE_RESET);
    send_ticks(9);
  endtask

  task automatic test_random_phase(input int send_pct, input int recv_pct,
                                   input logic [7:0] div, input int count);
    int sent;
    int n;
    logic [7:0] b;
    write_tick_divide(div);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 3) != 0) begin
        for (int i = 0; i < 6; i++) begin
          if ($urandom_range(0, 9) == 0) b = 8'($urandom_range(0, 255));
          else b = 8'd48 + 8'($urandom_range(0, 9));
          send_request(MODE_RX, b);
        end
        n = $urandom_range(0, 3 * (int'(div) + 1) + 2);
        send_ticks(n);
        sent += 6 + n;
      end else begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
          send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        sent += n;
      end
    end
  endtask

  always @(posedge clk) begin : lcd_checker
    lcd_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (lcd_expected.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: unexpected LCD byte: expected none, actual %h last %b",
                   $time, m_tdata, m_tlast);
      end else begin
        want = lcd_expected.pop_front();
        if (want.lcd_byte !== m_tdata || want.last !== m_tlast) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: LCD byte: expected %h last %b, actual %h last %b",
                     $time, want.lcd_byte, want.last, m_tdata, m_tlast);
        end
      end
    end
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin
    for (int i = 0; i < 6; i++) digit_reg[i] = 4'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_ticks_before_set();
    test_non_digit_load();
    test_default_divide();
    test_carry_and_rollover();
    test_divide_extremes();
    test_random_phase(20, 55, 8'($urandom_range(0, 2)), 65);
    test_random_phase(55, 20, 8'($urandom_range(1, 4)), 65);
    test_random_phase(0, 0, 8'd0, 65);
    wait_until_drained();
    if (error_count == 0) begin
      $display("clock_with_serial_set_and_lcd_frames: match");
    end else begin
      $display("clock_with_serial_set_and_lcd_frames: mismatch");
    end
    $finish;
  end

endmodule
